FILE: hdl/wplt_pkg.sv
// ----------------------------------------------------------------------------
// wplt_pkg
// Shared types and constants for the windowed peak loss tracker.
// ----------------------------------------------------------------------------
package wplt_pkg;

    localparam int LOSS_W = 8;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [LOSS_W-1:0] loss;
    } hist_entry_t;

    typedef struct packed {
        logic                  we;
        logic [5:0]            addr;
        hist_entry_t           data;
    } hist_wr_t;

    typedef struct packed {
        logic              age_ok;
        logic [LOSS_W-1:0] peak;
    } cmp_res_t;

endpackage

FILE: hdl/wplt_hist.sv
// ----------------------------------------------------------------------------
// wplt_hist
// History memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wplt_hist
    import wplt_pkg::*;
#(
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic        clk,
    input  hist_wr_t    wr,
    input  logic [AW-1:0] raddr,
    output hist_entry_t rdata
);

    hist_entry_t mem [DEPTH];
    hist_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wplt_cmp.sv
// ----------------------------------------------------------------------------
// wplt_cmp
// Shared age compare and peak select unit used by the update check and query walk steps.
// ----------------------------------------------------------------------------
module wplt_cmp
    import wplt_pkg::*;
(
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] tstamp,
    input  logic [TIME_W-1:0] limit,
    input  logic              incl,
    input  logic [LOSS_W-1:0] a,
    input  logic [LOSS_W-1:0] b,
    output cmp_res_t          res
);

    logic [TIME_W-1:0] age;

    always_comb
    begin
        age        = now - tstamp;
        res.age_ok = incl ? (age <= limit) : (age < limit);
        res.peak   = (b > a) ? b : a;
    end

endmodule

FILE: hdl/windowed_peak_loss_tracker_top.sv
// ----------------------------------------------------------------------------
// windowed_peak_loss_tracker_top
// Sliding window maximum of 8-bit loss reports over a circular history.
// ----------------------------------------------------------------------------
// Usage
// - input channel in_valid/in_ready carries kind, loss_sample and time_ms;
//   kind update folds a sample, kind query asks for the windowed maximum
// - output channel out_valid/out_ready carries max_loss, one per query
// - cfg_we/cfg_wdata writes window_ms; the user must write it only while
//   idle, since the block itself does not enforce this
// Sequence
// - update: accepted, then ST_UCHK checks the newest entry and the block is
//   ready again; the first update after reset writes entry 0 directly
// - query: one history read per cycle over the n entries examined, then
//   ST_QOUT loads the output register and the block is ready again;
//   the walk is set by the single read port of the history memory
// Reset
// - history empty (fill count zero), peak cleared, window_ms back to 1000
// Stall
// - the next request is taken while a result waits; a query that finishes
//   while the output register is still full holds until it is taken
// ----------------------------------------------------------------------------
module windowed_peak_loss_tracker_top
    import wplt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [LOSS_W-1:0] loss_sample,
    input  logic [TIME_W-1:0] time_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LOSS_W-1:0] max_loss,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_wdata
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(HISTORY_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UCHK = 2'd1;
    localparam logic [1:0] ST_QCHK = 2'd2;
    localparam logic [1:0] ST_QOUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [LOSS_W-1:0] peak_reg, peak_next;
    logic [LOSS_W-1:0] best_reg, best_next;
    logic [LOSS_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [WIN_W-1:0]  window_reg;
    logic              out_valid_reg, out_valid_next;
    logic [LOSS_W-1:0] max_loss_reg, max_loss_next;

    hist_wr_t          hist_wr;
    hist_entry_t       hist_rd;
    logic [AW-1:0]     rd_addr;
    logic [AW:0]       addr_sum;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] cmp_limit;
    logic              cmp_incl;
    logic [LOSS_W-1:0] cmp_a;
    logic [LOSS_W-1:0] cmp_b;
    cmp_res_t          cmp_res;
    logic              in_take;

    assign span      = TIME_W'(window_reg) * TIME_W'(HISTORY_DEPTH);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign max_loss  = max_loss_reg;

    // next entry of the walk, wrapped round the circular history
    assign addr_sum = (AW + 1)'(head_reg) + (AW + 1)'(idx_reg) + (AW + 1)'(1);

    always_comb
    begin
        if (state_reg == ST_QCHK)
        begin
            rd_addr = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : AW'(addr_sum);
        end
        else
        begin
            rd_addr = head_reg;
        end
    end

    always_comb
    begin
        if (state_reg == ST_UCHK)
        begin
            cmp_limit = TIME_W'(window_reg);
            cmp_incl  = 1'b0;
            cmp_a     = peak_reg;
            cmp_b     = sample_reg;
        end
        else
        begin
            cmp_limit = span;
            cmp_incl  = 1'b1;
            cmp_a     = best_reg;
            cmp_b     = hist_rd.loss;
        end
    end

    wplt_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .wr    (hist_wr),
        .raddr (rd_addr),
        .rdata (hist_rd)
    );

    wplt_cmp u_cmp (
        .now    (now_reg),
        .tstamp (hist_rd.tstamp),
        .limit  (cmp_limit),
        .incl   (cmp_incl),
        .a      (cmp_a),
        .b      (cmp_b),
        .res    (cmp_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        peak_next      = peak_reg;
        best_next      = best_reg;
        sample_next    = sample_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !out_ready;
        max_loss_next  = max_loss_reg;
        hist_wr.we          = 1'b0;
        hist_wr.addr        = 6'(head_reg);
        hist_wr.data.tstamp = now_reg;
        hist_wr.data.loss   = sample_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = loss_sample;
                    now_next    = time_ms;
                    if (kind == KIND_UPDATE)
                    begin
                        if (fill_reg == '0)
                        begin
                            // first update: entry 0 opens without a shift
                            hist_wr.we          = 1'b1;
                            hist_wr.data.tstamp = time_ms;
                            hist_wr.data.loss   = loss_sample;
                            fill_next           = CW'(1);
                            peak_next           = '0;
                        end
                        else
                        begin
                            state_next = ST_UCHK;
                        end
                    end
                    else
                    begin
                        best_next  = peak_reg;
                        idx_next   = '0;
                        state_next = (fill_reg == '0) ? ST_QOUT : ST_QCHK;
                    end
                end
            end
            ST_UCHK:
            begin
                state_next = ST_IDLE;
                if (cmp_res.age_ok)
                begin
                    peak_next = cmp_res.peak;
                end
                else
                begin
                    // close the window: shift by moving the head back
                    head_next         = (head_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                         : head_reg - AW'(1);
                    hist_wr.we        = 1'b1;
                    hist_wr.addr      = 6'(head_next);
                    hist_wr.data.loss = (peak_reg == '0) ? sample_reg : peak_reg;
                    fill_next         = (fill_reg == FILL_MAX) ? fill_reg
                                                               : fill_reg + CW'(1);
                    peak_next         = '0;
                end
            end
            ST_QCHK:
            begin
                if (!cmp_res.age_ok)
                begin
                    state_next = ST_QOUT;
                end
                else
                begin
                    best_next = cmp_res.peak;
                    if (idx_reg + CW'(1) == fill_reg)
                    begin
                        state_next = ST_QOUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            ST_QOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    max_loss_next  = best_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            peak_reg      <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        sample_reg   <= sample_next;
        now_reg      <= now_next;
        max_loss_reg <= max_loss_next;
    end

`ifndef ASSERT_OFF
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("history fill count beyond depth");

    a_write_fills : assert property (@(posedge clk) disable iff (!rst_n)
        hist_wr.we |=> fill_reg != '0)
        else $error("history written but still empty");

    a_walk_bound : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_QCHK |-> idx_reg < fill_reg)
        else $error("query walk past filled history");

    a_close_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UCHK && hist_wr.we) |=>
            (fill_reg == $past(fill_reg) + CW'(1) || fill_reg == FILL_MAX))
        else $error("window close did not grow history");
`endif

endmodule
